// ----- rtl/prrvm_pkg.sv -----
// Shared types and sizing constants for the round-robin virtual-channel multiplexer.
package prrvm_pkg;

    // Sizing of the multiplexer.
    localparam int NUM_INPUTS  = 4;
    localparam int QUEUE_DEPTH = 8;
    localparam int FLIT_WIDTH  = 32;

    // Derived widths.
    localparam int PORT_W = $clog2(NUM_INPUTS);
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Request codes carried in req_type.
    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // One input transaction: either a flit arrival or a dispatch tick.
    typedef struct packed {
        logic        req_type;
        logic [1:0]  in_port;
        logic [31:0] flit_data;
        logic        flit_head;
        logic        flit_tail;
        logic [3:0]  down_stop;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic        out_valid;
        logic [1:0]  out_channel;
        logic [31:0] out_data;
        logic        out_head;
        logic        out_tail;
        logic [3:0]  up_stop;
        logic        overflow;
    } t_out_item;

    // One stored flit.
    typedef struct packed {
        logic [FLIT_WIDTH-1:0] data;
        logic                  head;
        logic                  tail;
    } t_flit;

endpackage

// ----- rtl/packet_round_robin_vc_mux_unit.sv -----
// Round-robin virtual-channel multiplexer with per-input flit queues.
//
// The block takes transactions on an input channel (i_in_valid / o_in_ready,
// payload i_in_item) and returns exactly one result transaction for each of
// them on an output channel (o_out_valid / i_out_ready, payload o_out_item).
// An input transaction is either a flit arrival, which is queued in the FIFO
// of its input port, or a dispatch tick, which may send one flit.
// Each accepted transaction is held in the input register; from there the
// queue update and grant decision are made and the result is captured in
// the output register.
// Throughput is one transaction per cycle for as long as the receiver takes
// results; the queue state is touched in a single stage, so consecutive
// transactions see each other's effects without any bubble.
// When the receiver stalls, the result waits in the output register and one
// more transaction can still be taken into the input register; after that
// o_in_ready drops until the output drains.
// A synchronous active-low reset empties all queues, clears the lock and
// restarts the round-robin search at input 0. The flit storage itself is not
// cleared; an entry is only read after it has been written.
module packet_round_robin_vc_mux_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  prrvm_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output prrvm_pkg::t_out_item o_out_item
);
    import prrvm_pkg::*;

    // Pipeline registers.
    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    t_out_item n_out;

    // Per-input queue state.
    t_flit             r_store [NUM_INPUTS][QUEUE_DEPTH];
    logic [CNT_W-1:0]  r_count [NUM_INPUTS];
    logic [CNT_W-1:0]  n_count [NUM_INPUTS];
    logic [PTR_W-1:0]  r_rd_ptr [NUM_INPUTS];
    logic [PTR_W-1:0]  n_rd_ptr [NUM_INPUTS];
    logic [PTR_W-1:0]  r_wr_ptr [NUM_INPUTS];
    logic [PTR_W-1:0]  n_wr_ptr [NUM_INPUTS];

    // Arbitration state.
    logic              r_locked;
    logic              n_locked;
    logic [PORT_W-1:0] r_cur_port;
    logic [PORT_W-1:0] n_cur_port;
    logic [PORT_W-1:0] r_search;
    logic [PORT_W-1:0] n_search;

    // Working signals of the processing stage.
    logic              advance;
    logic              process;
    t_flit             front [NUM_INPUTS];
    logic [NUM_INPUTS-1:0] stopped;
    logic [NUM_INPUTS-1:0] eligible;
    logic [4:0]        port_ext;
    logic              port_ok;
    logic [PORT_W-1:0] port_idx;
    logic              st_we;
    t_flit             st_flit;
    logic [63:0]       data_ext;
    logic              found;
    logic [PORT_W-1:0] winner;
    logic [PORT_W:0]   rr_sum;
    logic              send;
    logic [PORT_W-1:0] ch;
    logic [63:0]       out_ext;
    logic [4:0]        ch_ext;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if ({1'b0, ptr} == (PTR_W+1)'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + PTR_W'(1);
        end
        return res;
    endfunction

    // The output register can take a new result when empty or being drained.
    assign advance    = !r_out_vld || i_out_ready;
    assign process    = r_in_vld && advance;
    assign o_in_ready = !r_in_vld || advance;

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // Oldest flit of every queue.
    always_comb begin
        for (int i = 0; i < NUM_INPUTS; i++) begin
            front[i] = r_store[i][r_rd_ptr[i]];
        end
    end

    // Downstream stop bits exist only for the first four channels.
    always_comb begin
        stopped = '0;
        for (int i = 0; i < NUM_INPUTS; i++) begin
            if (i < 4) begin
                stopped[i] = r_in.down_stop[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_INPUTS; i++) begin
            eligible[i] = (r_count[i] != '0) && !stopped[i];
        end
    end

    // Round-robin search starting at r_search. Walking the offsets from the
    // far end down lets the nearest eligible input overwrite the others.
    always_comb begin
        found  = 1'b0;
        winner = '0;
        rr_sum = '0;
        for (int k = NUM_INPUTS - 1; k >= 0; k--) begin
            rr_sum = {1'b0, r_search} + (PORT_W+1)'(k);
            if (rr_sum >= (PORT_W+1)'(NUM_INPUTS)) begin
                rr_sum = rr_sum - (PORT_W+1)'(NUM_INPUTS);
            end
            if (eligible[rr_sum[PORT_W-1:0]]) begin
                found  = 1'b1;
                winner = rr_sum[PORT_W-1:0];
            end
        end
    end

    // Arrival decode.
    assign port_ext = {3'b000, r_in.in_port};
    assign port_ok  = (port_ext < 5'(NUM_INPUTS));
    assign port_idx = port_ext[PORT_W-1:0];
    assign data_ext = {32'h0, r_in.flit_data};

    always_comb begin
        st_flit.data = data_ext[FLIT_WIDTH-1:0];
        st_flit.head = r_in.flit_head;
        st_flit.tail = r_in.flit_tail;
    end

    // Queue update, grant decision and result formation.
    always_comb begin
        n_count    = r_count;
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_locked   = r_locked;
        n_cur_port = r_cur_port;
        n_search   = r_search;
        n_out      = '0;
        st_we      = 1'b0;
        send       = 1'b0;
        ch         = r_cur_port;
        out_ext    = '0;
        ch_ext     = '0;

        if (process) begin
            if (r_in.req_type == REQ_ARRIVE) begin
                if (port_ok) begin
                    if (r_count[port_idx] == CNT_W'(QUEUE_DEPTH)) begin
                        n_out.overflow = 1'b1;
                    end else begin
                        st_we              = 1'b1;
                        n_wr_ptr[port_idx] = next_ptr(r_wr_ptr[port_idx]);
                        n_count[port_idx]  = r_count[port_idx] + CNT_W'(1);
                    end
                end
            end else begin
                if (r_locked) begin
                    // A header waits for its downstream channel; body flits do not.
                    if ((r_count[ch] != '0) && (!stopped[ch] || !front[ch].head)) begin
                        send = 1'b1;
                    end
                end else if (found) begin
                    ch         = winner;
                    send       = 1'b1;
                    n_cur_port = winner;
                    n_locked   = 1'b1;
                    if ({1'b0, winner} == (PORT_W+1)'(NUM_INPUTS - 1)) begin
                        n_search = '0;
                    end else begin
                        n_search = winner + PORT_W'(1);
                    end
                end
                if (send) begin
                    n_rd_ptr[ch]      = next_ptr(r_rd_ptr[ch]);
                    n_count[ch]       = r_count[ch] - CNT_W'(1);
                    out_ext           = 64'(front[ch].data);
                    ch_ext            = 5'(ch);
                    n_out.out_valid   = 1'b1;
                    n_out.out_channel = ch_ext[1:0];
                    n_out.out_data    = out_ext[31:0];
                    n_out.out_head    = front[ch].head;
                    n_out.out_tail    = front[ch].tail;
                    if (front[ch].tail) begin
                        n_locked = 1'b0;
                    end
                end
            end
            // Upstream stop reflects queue occupancy after this transaction.
            for (int i = 0; i < 4; i++) begin
                if (i < NUM_INPUTS) begin
                    n_out.up_stop[i] = (n_count[i] != '0);
                end
            end
        end
    end

    // Flit storage: no reset, entries are written before they are read.
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[port_idx][r_wr_ptr[port_idx]] <= st_flit;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_locked   <= 1'b0;
            r_cur_port <= '0;
            r_search   <= '0;
            for (int i = 0; i < NUM_INPUTS; i++) begin
                r_count[i]  <= '0;
                r_rd_ptr[i] <= '0;
                r_wr_ptr[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
            r_locked   <= n_locked;
            r_cur_port <= n_cur_port;
            r_search   <= n_search;
            r_count    <= n_count;
            r_rd_ptr   <= n_rd_ptr;
            r_wr_ptr   <= n_wr_ptr;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (process) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/prrvm_checker.sv -----
// Port-level checks for the round-robin virtual-channel multiplexer, bound to the top level.
module prrvm_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input prrvm_pkg::t_in_item  i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input prrvm_pkg::t_out_item o_out_item
);
    import prrvm_pkg::*;

    // A transaction that sends no flit carries an all-zero flit payload.
    a_idle_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.out_valid) |->
            (o_out_item.out_channel == 2'd0 && o_out_item.out_data == 32'd0 &&
             !o_out_item.out_head && !o_out_item.out_tail))
        else $error("non-sending result carries flit fields");

    // Overflow is only reported on arrivals, which never send a flit.
    a_overflow_no_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.overflow) |-> !o_out_item.out_valid)
        else $error("overflow flagged together with a sent flit");

    // No result can appear in the first cycle after reset is released.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result present right after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    // A waiting input transaction keeps its payload until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> (i_in_valid && $stable(i_in_item)))
        else $error("waiting input transaction changed");

endmodule

bind packet_round_robin_vc_mux_unit prrvm_checker u_prrvm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ----- bench/packet_round_robin_vc_mux_unit_tb.sv -----
// Self-checking bench for the round-robin virtual-channel multiplexer, predicted flit by flit.
`timescale 1ns / 100ps

module packet_round_robin_vc_mux_unit_tb;
    import prrvm_pkg::*;

    // Cycles without any accepted transaction or taken result before the run is declared hung.
    localparam int QUIET_LIMIT = 1000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    packet_round_robin_vc_mux_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // Predicted copy of the queue and arbiter state.
    t_flit             fifo_mem [NUM_INPUTS][QUEUE_DEPTH];
    logic [CNT_W-1:0]  fill     [NUM_INPUTS];
    logic [PTR_W-1:0]  rd_ptr   [NUM_INPUTS];
    logic [PTR_W-1:0]  wr_ptr   [NUM_INPUTS];
    logic              lock_on;
    logic [PORT_W-1:0] lock_port;
    logic [PORT_W-1:0] rr_next;

    // Results predicted for accepted transactions, oldest first.
    t_out_item results_due [$];

    // Flits still owed to the packet being built on each input.
    int pkt_left [NUM_INPUTS];

    // When clear, neither side inserts gaps or stalls.
    bit gaps_on;
    int err_count;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Only channels 0 to 3 have a downstream stop bit.
    function automatic bit chan_stopped(logic [3:0] stops, int ch);
        return (ch < 4) && stops[ch];
    endfunction

    // Advances the predicted state by one transaction and returns its result.
    function automatic t_out_item predict_mux_result(t_in_item it);
        t_out_item res;
        t_flit     fl;
        int        ch;
        int        c;
        int        k;
        bit        send;
        res  = '0;
        send = 1'b0;
        ch   = 0;
        if (it.req_type == REQ_ARRIVE) begin
            ch = int'(it.in_port);
            if (ch < NUM_INPUTS) begin
                if (fill[ch] >= QUEUE_DEPTH) begin
                    res.overflow = 1'b1;
                end else begin
                    fl.data = it.flit_data[FLIT_WIDTH-1:0];
                    fl.head = it.flit_head;
                    fl.tail = it.flit_tail;
                    fifo_mem[ch][wr_ptr[ch]] = fl;
                    wr_ptr[ch] = PTR_W'((int'(wr_ptr[ch]) + 1) % QUEUE_DEPTH);
                    fill[ch]   = fill[ch] + CNT_W'(1);
                end
            end
        end else if (lock_on) begin
            // A locked header still honors the stop bit; body and tail do not.
            ch = int'(lock_port);
            if (fill[ch] != 0) begin
                fl   = fifo_mem[ch][rd_ptr[ch]];
                send = !chan_stopped(it.down_stop, ch) || !fl.head;
            end
        end else begin
            for (k = 0; k < NUM_INPUTS && !send; k++) begin
                c = (int'(rr_next) + k) % NUM_INPUTS;
                if (fill[c] != 0 && !chan_stopped(it.down_stop, c)) begin
                    ch        = c;
                    send      = 1'b1;
                    lock_port = PORT_W'(c);
                    rr_next   = PORT_W'((c + 1) % NUM_INPUTS);
                    lock_on   = 1'b1;
                end
            end
        end
        if (send) begin
            fl = fifo_mem[ch][rd_ptr[ch]];
            rd_ptr[ch]      = PTR_W'((int'(rd_ptr[ch]) + 1) % QUEUE_DEPTH);
            fill[ch]        = fill[ch] - CNT_W'(1);
            res.out_valid   = 1'b1;
            res.out_channel = 2'(ch);
            res.out_data    = fl.data;
            res.out_head    = fl.head;
            res.out_tail    = fl.tail;
            if (fl.tail) lock_on = 1'b0;
        end
        for (k = 0; k < NUM_INPUTS && k < 4; k++) res.up_stop[k] = (fill[k] != 0);
        return res;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        it.req_type  = 1'($urandom_range(0, 1));
        it.in_port   = 2'($urandom_range(0, 3));
        it.flit_data = $urandom();
        it.flit_head = 1'($urandom_range(0, 1));
        it.flit_tail = 1'($urandom_range(0, 1));
        it.down_stop = 4'($urandom_range(0, 15));
        return it;
    endfunction

    function automatic t_in_item arrive_item(int port, logic [31:0] data, bit head, bit tail);
        t_in_item it;
        it           = random_item();
        it.req_type  = REQ_ARRIVE;
        it.in_port   = 2'(port);
        it.flit_data = data;
        it.flit_head = head;
        it.flit_tail = tail;
        return it;
    endfunction

    function automatic t_in_item tick_item(logic [3:0] stops);
        t_in_item it;
        it           = random_item();
        it.req_type  = REQ_TICK;
        it.down_stop = stops;
        return it;
    endfunction

    // Presents one transaction and records its prediction once it is taken.
    // Valid is only lowered when a gap follows, so it never toggles within a step.
    task automatic send_item(input t_in_item item);
        int gap;
        gap = gaps_on ? int'($urandom_range(0, 3)) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
        results_due.push_back(predict_mux_result(item));
    endtask

    task automatic test_empty_ticks();
        send_item(tick_item(4'h0));
        send_item(tick_item(4'hF));
    endtask

    // A three-flit packet on input 0 with a single-flit packet waiting on input 1.
    task automatic test_packet_lock();
        send_item(arrive_item(0, 32'h0000_0000, 1'b1, 1'b0));
        send_item(arrive_item(0, $urandom(), 1'b0, 1'b0));
        send_item(arrive_item(1, $urandom(), 1'b1, 1'b1));
        send_item(tick_item(4'h0));
        // The body goes out even though its channel is stopped.
        send_item(tick_item(4'b0001));
        // Locked onto an empty queue: nothing is sent and the lock holds.
        send_item(tick_item(4'h0));
        send_item(arrive_item(0, 32'hFFFF_FFFF, 1'b0, 1'b1));
        send_item(tick_item(4'hF));
        // Unlocked, but the only waiting input is stopped.
        send_item(tick_item(4'b0010));
        send_item(tick_item(4'h0));
    endtask

    // Two headers in a row: the second one waits on its stop bit while locked.
    task automatic test_locked_header_wait();
        send_item(arrive_item(2, $urandom(), 1'b1, 1'b0));
        send_item(arrive_item(2, $urandom(), 1'b1, 1'b0));
        send_item(tick_item(4'h0));
        send_item(tick_item(4'b0100));
        send_item(tick_item(4'h0));
    endtask

    // The ninth flit into one queue finds it full and is dropped.
    task automatic test_queue_overflow();
        int n;
        for (n = 0; n <= QUEUE_DEPTH; n++) send_item(arrive_item(3, $urandom(), 1'b1, 1'b1));
    endtask

    // Mostly well-formed packets on random inputs, mixed with ticks and stray flits.
    task automatic drive_random_traffic(input int count, input int arrive_pct);
        t_in_item it;
        int       n;
        int       roll;
        int       port;
        for (n = 0; n < count; n++) begin
            // Every third stretch runs without gaps or stalls.
            gaps_on = ((n / 96) % 3) != 0;
            roll    = int'($urandom_range(0, 99));
            it      = random_item();
            if (roll < arrive_pct) begin
                port         = int'($urandom_range(0, NUM_INPUTS - 1));
                it.req_type  = REQ_ARRIVE;
                it.in_port   = 2'(port);
                it.flit_head = (pkt_left[port] == 0);
                if (it.flit_head) pkt_left[port] = int'($urandom_range(1, 5));
                pkt_left[port] = pkt_left[port] - 1;
                it.flit_tail = (pkt_left[port] == 0);
            end else if (roll < arrive_pct + 8) begin
                it.req_type = REQ_ARRIVE;
            end else begin
                it.req_type = REQ_TICK;
                if ($urandom_range(0, 1) == 0) it.down_stop = 4'h0;
            end
            send_item(it);
        end
    endtask

    task automatic test_random_packets();
        drive_random_traffic(900, 46);
    endtask

    // Arrivals outpace ticks until queues overflow, then ticks drain them.
    task automatic test_congestion();
        drive_random_traffic(325, 75);
        drive_random_traffic(325, 15);
    endtask

    // Result side: random stalls per transaction, and a field-by-field check.
    initial begin
        t_out_item want;
        int        stall;
        bit        bad;
        out_ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            stall = gaps_on ? int'($urandom_range(0, 3)) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (results_due.size() == 0) begin
                err_count++;
                if (err_count <= 10) $display("unexpected result: %p", out_item);
            end else begin
                want = results_due.pop_front();
                bad  = (out_item.out_valid   !== want.out_valid)   ||
                       (out_item.out_channel !== want.out_channel) ||
                       (out_item.out_data    !== want.out_data)    ||
                       (out_item.out_head    !== want.out_head)    ||
                       (out_item.out_tail    !== want.out_tail)    ||
                       (out_item.up_stop     !== want.up_stop)     ||
                       (out_item.overflow    !== want.overflow);
                if (bad) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("mismatch: expected v=%0d ch=%0d d=%h h=%0d t=%0d up=%b ov=%0d",
                                 want.out_valid, want.out_channel, want.out_data,
                                 want.out_head, want.out_tail, want.up_stop, want.overflow);
                        $display("          actual   v=%0d ch=%0d d=%h h=%0d t=%0d up=%b ov=%0d",
                                 out_item.out_valid, out_item.out_channel, out_item.out_data,
                                 out_item.out_head, out_item.out_tail, out_item.up_stop,
                                 out_item.overflow);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int p;
        int q;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        gaps_on   = 1'b1;
        err_count = 0;
        lock_on   = 1'b0;
        lock_port = '0;
        rr_next   = '0;
        for (p = 0; p < NUM_INPUTS; p++) begin
            fill[p]     = '0;
            rd_ptr[p]   = '0;
            wr_ptr[p]   = '0;
            pkt_left[p] = 0;
            for (q = 0; q < QUEUE_DEPTH; q++) fifo_mem[p][q] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_ticks();
        test_packet_lock();
        test_locked_header_wait();
        test_queue_overflow();
        test_random_packets();
        test_congestion();

        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        // Keep clocking after the queue empties so a stray extra result would still be caught.
        repeat (8) @(posedge clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
